// ===== hw/rtl/bmp_pkg.sv =====
// Shared constants, payload types and build states for the binomial block.
package bmp_pkg;

    localparam int MOD_W          = 31;
    localparam int IDX_W          = 12;
    localparam int TABLE_SIZE_DEF = 2048;
    localparam int QUEUE_DEPTH    = 4;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_MULTI  = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] k;
    } query_t;

    typedef struct packed {
        logic [MOD_W-1:0] value;
        logic             out_of_table;
    } result_t;

    typedef enum logic [2:0] {
        BS_INIT,
        BS_DIV,
        BS_READ,
        BS_MUL_T,
        BS_MUL_F,
        BS_MUL_I,
        BS_WRITE,
        BS_DONE
    } build_state_t;

endpackage

// ===== hw/rtl/bmp_chan_if.sv =====
// Valid/ready channel carrying one item of type T.
interface bmp_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bmp_fifo.sv =====
// Small register queue between the front and back sections.
module bmp_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = bmp_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output logic [DW-1:0] head_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/bmp_modmul.sv =====
// Pipelined modular multiplier, one bit of the multiplier operand per stage.
module bmp_modmul #(
    parameter int TW = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [bmp_pkg::MOD_W-1:0] a,
    input  logic [bmp_pkg::MOD_W-1:0] b,
    input  logic [TW-1:0]             tag_in,
    input  logic [bmp_pkg::MOD_W-1:0] m,
    output logic                      out_valid,
    output logic [bmp_pkg::MOD_W-1:0] product,
    output logic [TW-1:0]             tag_out
);
    import bmp_pkg::*;

    // a must already be below m; b may be any value.
    function automatic logic [MOD_W-1:0] mm_step(
        input logic [MOD_W-1:0] r,
        input logic [MOD_W-1:0] addend,
        input logic             bit_in,
        input logic [MOD_W-1:0] mod
    );
        logic [MOD_W+1:0] s;
        logic [MOD_W+1:0] m1;
        logic [MOD_W+1:0] m2;
        s  = {1'b0, r, 1'b0} + {2'b00, (bit_in ? addend : {MOD_W{1'b0}})};
        m1 = {2'b00, mod};
        m2 = {1'b0, mod, 1'b0};
        if (s >= m2)
        begin
            mm_step = MOD_W'(s - m2);
        end
        else if (s >= m1)
        begin
            mm_step = MOD_W'(s - m1);
        end
        else
        begin
            mm_step = MOD_W'(s);
        end
    endfunction

    logic             valid_reg [MOD_W];
    logic [MOD_W-1:0] r_reg     [MOD_W];
    logic [MOD_W-1:0] a_reg     [MOD_W];
    logic [MOD_W-1:0] b_reg     [MOD_W];
    logic [TW-1:0]    tag_reg   [MOD_W];

    for (genvar gi = 0; gi < MOD_W; gi++)
    begin : g_stage
        logic             v_in;
        logic [MOD_W-1:0] r_in;
        logic [MOD_W-1:0] a_in;
        logic [MOD_W-1:0] b_in;
        logic [TW-1:0]    t_in;

        if (gi == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign a_in = a;
            assign b_in = b;
            assign t_in = tag_in;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[gi-1];
            assign r_in = r_reg[gi-1];
            assign a_in = a_reg[gi-1];
            assign b_in = b_reg[gi-1];
            assign t_in = tag_reg[gi-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[gi] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[gi] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[gi]   <= mm_step(r_in, a_in, b_in[MOD_W-1-gi], m);
                a_reg[gi]   <= a_in;
                b_reg[gi]   <= b_in;
                tag_reg[gi] <= t_in;
            end
        end
    end

    assign out_valid = valid_reg[MOD_W-1];
    assign product   = r_reg[MOD_W-1];
    assign tag_out   = tag_reg[MOD_W-1];
endmodule

// ===== hw/rtl/bmp_build.sv =====
// Table builder: fills factorial and inverse-factorial tables for the modulus.
module bmp_build #(
    parameter int TABLE_SIZE = bmp_pkg::TABLE_SIZE_DEF,
    parameter int AW         = $clog2(TABLE_SIZE)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  logic [bmp_pkg::MOD_W-1:0] m,
    output logic                      tables_ready,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [bmp_pkg::MOD_W-1:0] wr_fact,
    output logic [bmp_pkg::MOD_W-1:0] wr_ifact
);
    import bmp_pkg::*;

    localparam int CNT_W = $clog2(MOD_W);

    build_state_t state_reg, state_next;

    logic [AW-1:0]    j_reg;
    logic [MOD_W-1:0] dvd_reg;
    logic [AW:0]      rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MOD_W-1:0] fact_reg;
    logic [MOD_W-1:0] ifact_reg;
    logic [MOD_W-1:0] iv_reg;
    logic             issued_reg;

    logic [MOD_W-1:0] inv_mem [TABLE_SIZE];
    logic [MOD_W-1:0] inv_rd_reg;

    logic             mm_in_valid;
    logic [MOD_W-1:0] mm_a;
    logic [MOD_W-1:0] mm_b;
    logic             mm_out_valid;
    logic [MOD_W-1:0] mm_product;
    logic             mm_tag_unused;

    logic [AW:0]      rem_shift;
    logic             qbit;
    logic             is_mul;
    logic             last_j;

    assign rem_shift = {rem_reg[AW-1:0], dvd_reg[MOD_W-1]};
    assign qbit      = (rem_shift >= {1'b0, j_reg});
    assign is_mul    = (state_reg == BS_MUL_T) || (state_reg == BS_MUL_F)
                    || (state_reg == BS_MUL_I);
    assign last_j    = (j_reg == AW'(TABLE_SIZE - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_INIT:  state_next = (m < MOD_W'(2)) ? BS_DONE : BS_DIV;
            BS_DIV:   state_next = (cnt_reg == CNT_W'(MOD_W - 1)) ? BS_READ : BS_DIV;
            BS_READ:  state_next = (j_reg == AW'(1)) ? BS_MUL_F : BS_MUL_T;
            BS_MUL_T: state_next = mm_out_valid ? BS_MUL_F : BS_MUL_T;
            BS_MUL_F: state_next = mm_out_valid ? BS_MUL_I : BS_MUL_F;
            BS_MUL_I: state_next = mm_out_valid ? BS_WRITE : BS_MUL_I;
            BS_WRITE: state_next = last_j ? BS_DONE : BS_DIV;
            BS_DONE:  state_next = BS_DONE;
            default:  state_next = BS_INIT;
        endcase
    end

    always_comb
    begin
        tables_ready = (state_reg == BS_DONE);
        wr_en        = 1'b0;
        wr_addr      = j_reg;
        wr_fact      = fact_reg;
        wr_ifact     = ifact_reg;
        mm_in_valid  = is_mul && !issued_reg;
        mm_a         = fact_reg;
        mm_b         = MOD_W'(j_reg);
        unique case (state_reg)
            BS_INIT:
            begin
                wr_en    = (m >= MOD_W'(2));
                wr_addr  = '0;
                wr_fact  = MOD_W'(1);
                wr_ifact = MOD_W'(1);
            end
            BS_MUL_T:
            begin
                mm_a = inv_rd_reg;
                mm_b = dvd_reg;
            end
            BS_MUL_I:
            begin
                mm_a = ifact_reg;
                mm_b = iv_reg;
            end
            BS_WRITE: wr_en = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_INIT;
            issued_reg <= 1'b0;
        end
        else if (restart)
        begin
            state_reg  <= BS_INIT;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mm_out_valid)
            begin
                issued_reg <= 1'b0;
            end
            else if (mm_in_valid)
            begin
                issued_reg <= 1'b1;
            end
        end
    end

    // Datapath: restoring divider for m / j, then three multiplies per entry (two for entry 1).
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BS_INIT:
            begin
                fact_reg  <= MOD_W'(1);
                ifact_reg <= MOD_W'(1);
                j_reg     <= AW'(1);
                dvd_reg   <= m;
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            BS_DIV:
            begin
                dvd_reg <= {dvd_reg[MOD_W-2:0], qbit};
                rem_reg <= qbit ? (rem_shift - {1'b0, j_reg}) : rem_shift;
                cnt_reg <= cnt_reg + 1'b1;
            end
            BS_READ:
            begin
                iv_reg <= MOD_W'(1);
            end
            BS_MUL_T:
            begin
                if (mm_out_valid)
                begin
                    iv_reg <= (mm_product == '0) ? '0 : (m - mm_product);
                end
            end
            BS_MUL_F:
            begin
                if (mm_out_valid)
                begin
                    fact_reg <= mm_product;
                end
            end
            BS_MUL_I:
            begin
                if (mm_out_valid)
                begin
                    ifact_reg <= mm_product;
                end
            end
            BS_WRITE:
            begin
                j_reg   <= j_reg + 1'b1;
                dvd_reg <= m;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BS_INIT)
        begin
            inv_mem[0] <= MOD_W'(1);
        end
        else if (state_reg == BS_WRITE)
        begin
            inv_mem[j_reg] <= iv_reg;
        end
        inv_rd_reg <= inv_mem[rem_reg[AW-1:0]];
    end

    bmp_modmul #(.TW(1)) u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (1'b1),
        .in_valid  (mm_in_valid),
        .a         (mm_a),
        .b         (mm_b),
        .tag_in    (1'b0),
        .m         (m),
        .out_valid (mm_out_valid),
        .product   (mm_product),
        .tag_out   (mm_tag_unused)
    );
endmodule

// ===== hw/rtl/bmp_front.sv =====
// Front section: accepts queries and classifies them into table addresses.
module bmp_front #(
    parameter int TABLE_SIZE = bmp_pkg::TABLE_SIZE_DEF,
    parameter int AW         = $clog2(TABLE_SIZE)
) (
    bmp_chan_if.sink          in_ch,
    input  logic              accept_ok,
    output logic              push,
    output logic [3*AW+1:0]   push_data
);
    import bmp_pkg::*;

    logic [31:0] n32;
    logic [31:0] k32;
    logic [31:0] top32;
    logic [31:0] low32;
    logic        zero;
    logic        oot;

    assign in_ch.ready = accept_ok;
    assign push        = in_ch.valid && accept_ok;

    always_comb
    begin
        n32 = 32'(in_ch.data.n);
        k32 = 32'(in_ch.data.k);
        if (in_ch.data.operation == OP_MULTI)
        begin
            top32 = n32 + k32 - 32'd1;
            zero  = (in_ch.data.n == '0);
        end
        else
        begin
            top32 = n32;
            zero  = (in_ch.data.k > in_ch.data.n);
        end
        low32     = top32 - k32;
        oot       = !zero && (top32 >= 32'(TABLE_SIZE));
        push_data = {top32[AW-1:0], low32[AW-1:0], k32[AW-1:0], zero, oot};
    end
endmodule

// ===== hw/rtl/bmp_back.sv =====
// Back section: table reads, two modular multiplies and the output register.
module bmp_back #(
    parameter int TABLE_SIZE = bmp_pkg::TABLE_SIZE_DEF,
    parameter int AW         = $clog2(TABLE_SIZE)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bmp_pkg::MOD_W-1:0] m,
    input  logic                      q_valid,
    input  logic [3*AW+1:0]           q_data,
    output logic                      q_pop,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [bmp_pkg::MOD_W-1:0] wr_fact,
    input  logic [bmp_pkg::MOD_W-1:0] wr_ifact,
    bmp_chan_if.source                out_ch
);
    import bmp_pkg::*;

    logic [MOD_W-1:0] fact_mem  [TABLE_SIZE];
    logic [MOD_W-1:0] ifact_mem [TABLE_SIZE];

    logic             en;
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [AW-1:0]    addr_c;

    logic             rv_reg;
    logic             zero_reg;
    logic             oot_reg;
    logic [MOD_W-1:0] fa_reg;
    logic [MOD_W-1:0] ib_reg;
    logic [MOD_W-1:0] ic_reg;

    logic             m1_valid;
    logic [MOD_W-1:0] m1_product;
    logic [MOD_W+1:0] m1_tag;
    logic             m2_valid;
    logic [MOD_W-1:0] m2_product;
    logic [1:0]       m2_tag;

    logic             out_valid_reg;
    logic [MOD_W-1:0] value_reg;
    logic             oot_out_reg;

    // Whole pipeline holds while a finished item waits at the output.
    assign en    = !out_valid_reg || out_ch.ready;
    assign q_pop = en && q_valid;

    assign addr_a = q_data[3*AW+1:2*AW+2];
    assign addr_b = q_data[2*AW+1:AW+2];
    assign addr_c = q_data[AW+1:2];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fact_mem[wr_addr]  <= wr_fact;
            ifact_mem[wr_addr] <= wr_ifact;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_reg   <= fact_mem[addr_a];
            ib_reg   <= ifact_mem[addr_b];
            ic_reg   <= ifact_mem[addr_c];
            zero_reg <= q_data[1];
            oot_reg  <= q_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rv_reg        <= q_valid;
            out_valid_reg <= m2_valid;
        end
    end

    bmp_modmul #(.TW(MOD_W + 2)) u_mul_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rv_reg),
        .a         (fa_reg),
        .b         (ib_reg),
        .tag_in    ({ic_reg, zero_reg, oot_reg}),
        .m         (m),
        .out_valid (m1_valid),
        .product   (m1_product),
        .tag_out   (m1_tag)
    );

    bmp_modmul #(.TW(2)) u_mul_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m1_valid),
        .a         (m1_product),
        .b         (m1_tag[MOD_W+1:2]),
        .tag_in    (m1_tag[1:0]),
        .m         (m),
        .out_valid (m2_valid),
        .product   (m2_product),
        .tag_out   (m2_tag)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Drop the product for empty coefficients, big indexes or a tiny modulus.
            value_reg   <= (m2_tag[1] || m2_tag[0] || (m < MOD_W'(2))) ? '0 : m2_product;
            oot_out_reg <= m2_tag[0];
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.data.value        = value_reg;
    assign out_ch.data.out_of_table = oot_out_reg;
endmodule

// ===== hw/rtl/binomial_mod_prime.sv =====
// Top level of the binomial coefficient modulo prime block.
// Answers C(n,k) (operation 0) or C(n+k-1,k) (operation 1) modulo the prime in the
// modulus register, one item per cycle sustained while out_ch.ready stays high,
// computed through the two bit-per-stage modular multiplier pipelines. After reset and after
// every modulus write the block rebuilds its factorial and inverse-factorial tables
// and holds in_ch.ready low until done: each entry takes one 31-step division and
// three trips (two for entry 1) through a 31-stage multiplier. Indexes reaching
// TABLE_SIZE give 0 with out_of_table set; empty coefficients give 0.
module binomial_mod_prime #(
    parameter int TABLE_SIZE = bmp_pkg::TABLE_SIZE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bmp_pkg::MOD_W-1:0] cfg_data,
    bmp_chan_if.sink                  in_ch,
    bmp_chan_if.source                out_ch
);
    import bmp_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int QW = 3 * AW + 2;

    logic [MOD_W-1:0] modulus_reg;
    logic             tables_ready;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [MOD_W-1:0] wr_fact;
    logic [MOD_W-1:0] wr_ifact;
    logic             push;
    logic [QW-1:0]    push_data;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [QW-1:0]    q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_data;
        end
    end

    bmp_build #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_build (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_we),
        .m            (modulus_reg),
        .tables_ready (tables_ready),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_fact      (wr_fact),
        .wr_ifact     (wr_ifact)
    );

    bmp_front #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_front (
        .in_ch     (in_ch),
        .accept_ok (tables_ready && !q_full),
        .push      (push),
        .push_data (push_data)
    );

    bmp_fifo #(.DW(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    bmp_back #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .m        (modulus_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_fact  (wr_fact),
        .wr_ifact (wr_ifact),
        .out_ch   (out_ch)
    );
endmodule

// ===== hw/rtl/bmp_checker.sv =====
// Port-level checks for the binomial block, bound to the top level.
module bmp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [bmp_pkg::MOD_W-1:0] out_value,
    input logic                      out_oot
);
    import bmp_pkg::*;

    // A modulus write starts a rebuild, so no item may be taken right after it.
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input ready right after a modulus write");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_oot))
        else $error("stalled result changed");

    a_oot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_oot |-> out_value == '0)
        else $error("out-of-table result with nonzero value");
endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.data.value),
    .out_oot   (out_ch.data.out_of_table)
);
